[rtl/msq_pkg.sv]
// ----------------------------------------------------------------------------
// msq_pkg
// Shared types, constants and cell tables of the marching squares contour block.
// ----------------------------------------------------------------------------
package msq_pkg;

  localparam int CFG_BITS     = 11;
  localparam int CFG_IDX_BITS = 2;
  localparam int COORD_BITS   = 18;
  localparam int INDEX_BITS   = 21;
  localparam int MAX_HEIGHT   = 1024;
  localparam int ROW_BITS     = 10;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    EDGE_N = 2'd0,
    EDGE_E = 2'd1,
    EDGE_S = 2'd2,
    EDGE_W = 2'd3
  } edge_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SETUP,
    S_DIV,
    S_EMIT,
    S_FIN
  } state_e;

  // number of segments for a cell case
  function automatic logic [1:0] seg_count(logic [3:0] c);
    logic [1:0] n;
    begin
      if (c inside {4'd0, 4'd15}) begin
        n = 2'd0;
      end else if (c inside {4'd5, 4'd10}) begin
        n = 2'd2;
      end else begin
        n = 2'd1;
      end
      return n;
    end
  endfunction

  // edge of endpoint ep (start0, end0, start1, end1) for a cell case
  function automatic edge_e seg_edge(logic [3:0] c, logic [1:0] ep);
    edge_e e0;
    edge_e e1;
    edge_e e2;
    edge_e e3;
    edge_e r;
    begin
      e0 = EDGE_N;
      e1 = EDGE_N;
      e2 = EDGE_N;
      e3 = EDGE_N;
      case (c)
        4'd1: begin e0 = EDGE_W; e1 = EDGE_S; end
        4'd2: begin e0 = EDGE_S; e1 = EDGE_E; end
        4'd3: begin e0 = EDGE_W; e1 = EDGE_E; end
        4'd4: begin e0 = EDGE_E; e1 = EDGE_N; end
        4'd5: begin e0 = EDGE_E; e1 = EDGE_N; e2 = EDGE_W; e3 = EDGE_S; end
        4'd6: begin e0 = EDGE_S; e1 = EDGE_N; end
        4'd7: begin e0 = EDGE_W; e1 = EDGE_N; end
        4'd8: begin e0 = EDGE_N; e1 = EDGE_W; end
        4'd9: begin e0 = EDGE_N; e1 = EDGE_S; end
        4'd10: begin e0 = EDGE_S; e1 = EDGE_E; e2 = EDGE_N; e3 = EDGE_W; end
        4'd11: begin e0 = EDGE_N; e1 = EDGE_E; end
        4'd12: begin e0 = EDGE_E; e1 = EDGE_W; end
        4'd13: begin e0 = EDGE_E; e1 = EDGE_S; end
        4'd14: begin e0 = EDGE_S; e1 = EDGE_W; end
        default: begin e0 = EDGE_N; end
      endcase
      case (ep)
        2'd0: r = e0;
        2'd1: r = e1;
        2'd2: r = e2;
        default: r = e3;
      endcase
      return r;
    end
  endfunction

endpackage

[rtl/marching_squares_contour.sv]
// ----------------------------------------------------------------------------
// marching_squares_contour
// Streaming isoline extractor: forms 2x2 cells from a one-row store and emits
// up to two line segments per sample, edge fractions from a serial divider.
// ----------------------------------------------------------------------------
// a sample without a cell or without crossings passes only the read and finish
// states; with crossings, each of the E = 2 or 4 endpoints takes a setup state and
// the divide state, then the segments are emitted (held while the output stalls);
// one sample at a time; the restoring divider computes one quotient bit per
// cycle per endpoint
// reset clears counters, holding samples and config (1024 x 1024); the row
// store is not cleared and needs no clearing pass
module marching_squares_contour #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [msq_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [msq_pkg::CFG_BITS-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]       sample_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [msq_pkg::COORD_BITS-1:0]      start_x_o,
  output logic [msq_pkg::COORD_BITS-1:0]      start_y_o,
  output logic [msq_pkg::COORD_BITS-1:0]      end_x_o,
  output logic [msq_pkg::COORD_BITS-1:0]      end_y_o,
  output logic [msq_pkg::INDEX_BITS-1:0]      segment_index_o,
  output logic                                last_of_cell_o
);

  localparam int WB  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WWB = $clog2(MAX_WIDTH + 1);
  localparam int DW  = ((WWB > msq_pkg::CFG_BITS) ? WWB : msq_pkg::CFG_BITS) + 1;
  localparam int HW  = msq_pkg::ROW_BITS + 1;
  localparam int NW  = SAMPLE_BITS + 1;
  localparam int RW  = SAMPLE_BITS + 2;
  localparam int QW  = FRAC_BITS + 1;
  localparam int SW  = $clog2(FRAC_BITS + 1);
  localparam int XB  = (WB > msq_pkg::ROW_BITS) ? WB : msq_pkg::ROW_BITS;
  localparam int PW0 = XB + FRAC_BITS + 2;
  localparam int PW  = (PW0 > msq_pkg::COORD_BITS) ? PW0 : msq_pkg::COORD_BITS;
  localparam int CB  = msq_pkg::COORD_BITS;

  msq_pkg::state_e state_q, state_d;

  logic [msq_pkg::CFG_BITS-1:0] width_q, height_q;
  logic [WB-1:0]                col_q;
  logic [msq_pkg::ROW_BITS-1:0] row_q;
  logic [msq_pkg::INDEX_BITS-1:0] seg_cnt_q;

  logic signed [SAMPLE_BITS-1:0] cur_q, ul_q, left_q, rdata_q;
  logic signed [SAMPLE_BITS-1:0] row_mem [MAX_WIDTH];

  logic [3:0]    case_q;
  logic [1:0]    ep_q;
  logic          emk_q;
  logic [RW-1:0] rem_q;
  logic [NW-1:0] den_q;
  logic [QW-1:0] quo_q;
  logic [SW-1:0] step_q;
  logic [CB-1:0] pt_x_q [4];
  logic [CB-1:0] pt_y_q [4];

  logic          out_valid_q;
  logic [CB-1:0] start_x_q, start_y_q, end_x_q, end_y_q;
  logic [msq_pkg::INDEX_BITS-1:0] seg_idx_q;
  logic          last_q;

  // control from the sequencer
  logic in_fire, mem_we, load_div, div_step, load_out, fin;

  // sizes with out-of-range values clamped
  logic [DW-1:0] w_raw, w_eff;
  logic [HW-1:0] h_eff;
  always_comb begin
    w_raw = DW'(width_q);
    if (w_raw < DW'(2)) begin
      w_eff = DW'(2);
    end else if (w_raw > DW'(MAX_WIDTH)) begin
      w_eff = DW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (height_q < HW'(2)) begin
      h_eff = HW'(2);
    end else if (height_q > HW'(msq_pkg::MAX_HEIGHT)) begin
      h_eff = HW'(msq_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
  end

  logic       col_end, row_end, has_cell;
  logic [1:0] nseg;
  logic [3:0] case_d;
  assign col_end  = (DW'(col_q) + DW'(1)) >= w_eff;
  assign row_end  = (HW'(row_q) + HW'(1)) >= h_eff;
  assign has_cell = (row_q != '0) && (col_q != '0);
  assign nseg     = msq_pkg::seg_count(case_q);
  assign case_d   = {ul_q <= 0, rdata_q <= 0, cur_q <= 0, left_q <= 0};

  // operands of the current endpoint edge
  msq_pkg::edge_e cur_edge;
  logic signed [SAMPLE_BITS-1:0] p_s, q_s;
  logic [NW-1:0] p_ext, q_ext, diff, num_u, den_u;
  assign cur_edge = msq_pkg::seg_edge(case_q, ep_q);
  always_comb begin
    case (cur_edge)
      msq_pkg::EDGE_N: begin p_s = ul_q;   q_s = rdata_q; end
      msq_pkg::EDGE_E: begin p_s = rdata_q; q_s = cur_q;  end
      msq_pkg::EDGE_S: begin p_s = left_q; q_s = cur_q;   end
      default:         begin p_s = ul_q;   q_s = left_q;  end
    endcase
    p_ext = {p_s[SAMPLE_BITS-1], p_s};
    q_ext = {q_s[SAMPLE_BITS-1], q_s};
    diff  = p_ext - q_ext;
    num_u = p_ext[NW-1] ? (~p_ext + NW'(1)) : p_ext;
    den_u = diff[NW-1] ? (~diff + NW'(1)) : diff;
  end

  // shared compare-subtract unit, one quotient bit per cycle
  logic          ge;
  logic [RW-1:0] r1;
  logic [QW-1:0] quo_d;
  assign ge    = (den_q != '0) && (rem_q >= RW'(den_q));
  assign r1    = ge ? (rem_q - RW'(den_q)) : rem_q;
  assign quo_d = {quo_q[QW-2:0], ge};

  // endpoint coordinates
  logic [PW-1:0] ox, oy, one, frac, px, py;
  always_comb begin
    ox   = PW'(col_q - WB'(1)) << FRAC_BITS;
    oy   = PW'(row_q - msq_pkg::ROW_BITS'(1)) << FRAC_BITS;
    one  = PW'(1) << FRAC_BITS;
    frac = PW'(quo_d);
    case (cur_edge)
      msq_pkg::EDGE_N: begin px = ox + frac; py = oy;        end
      msq_pkg::EDGE_E: begin px = ox + one;  py = oy + frac; end
      msq_pkg::EDGE_S: begin px = ox + frac; py = oy + one;  end
      default:         begin px = ox;        py = oy + frac; end
    endcase
  end

  logic seg0_ok, seg1_ok, seg_ok, seg_last, last_seg;
  assign seg0_ok  = (pt_x_q[0] != pt_x_q[1]) || (pt_y_q[0] != pt_y_q[1]);
  assign seg1_ok  = (nseg == 2'd2) &&
                    ((pt_x_q[2] != pt_x_q[3]) || (pt_y_q[2] != pt_y_q[3]));
  assign seg_ok   = emk_q ? seg1_ok : seg0_ok;
  assign seg_last = emk_q || !seg1_ok;
  assign last_seg = emk_q || (nseg != 2'd2);

  // sequencer
  always_comb begin
    state_d  = state_q;
    in_fire  = 1'b0;
    mem_we   = 1'b0;
    load_div = 1'b0;
    div_step = 1'b0;
    load_out = 1'b0;
    fin      = 1'b0;
    case (state_q)
      msq_pkg::S_IDLE: begin
        in_fire = in_valid_i;
        if (in_valid_i) state_d = msq_pkg::S_READ;
      end
      msq_pkg::S_READ: begin
        mem_we = 1'b1;
        if (has_cell && (msq_pkg::seg_count(case_d) != 2'd0)) begin
          state_d = msq_pkg::S_SETUP;
        end else begin
          state_d = msq_pkg::S_FIN;
        end
      end
      msq_pkg::S_SETUP: begin
        load_div = 1'b1;
        state_d  = msq_pkg::S_DIV;
      end
      msq_pkg::S_DIV: begin
        div_step = 1'b1;
        if (step_q == SW'(FRAC_BITS)) begin
          if (ep_q == {nseg[1], 1'b1}) begin
            state_d = msq_pkg::S_EMIT;
          end else begin
            state_d = msq_pkg::S_SETUP;
          end
        end
      end
      msq_pkg::S_EMIT: begin
        if (!seg_ok) begin
          if (last_seg) state_d = msq_pkg::S_FIN;
        end else if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          if (last_seg) state_d = msq_pkg::S_FIN;
        end
      end
      msq_pkg::S_FIN: begin
        fin     = 1'b1;
        state_d = msq_pkg::S_IDLE;
      end
      default: state_d = msq_pkg::S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == msq_pkg::S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= msq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // row store
  always_ff @(posedge clk_i) begin
    if (mem_we) row_mem[col_q] <= cur_q;
    if (in_fire) rdata_q <= row_mem[col_q];
  end

  // config, counters and holding samples
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= msq_pkg::CFG_BITS'(1024);
      height_q  <= msq_pkg::CFG_BITS'(1024);
      col_q     <= '0;
      row_q     <= '0;
      seg_cnt_q <= '0;
      ul_q      <= '0;
      left_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          msq_pkg::REG_GRID_WIDTH: begin
            width_q   <= cfg_data_i;
            col_q     <= '0;
            row_q     <= '0;
            seg_cnt_q <= '0;
          end
          msq_pkg::REG_GRID_HEIGHT: begin
            height_q  <= cfg_data_i;
            col_q     <= '0;
            row_q     <= '0;
            seg_cnt_q <= '0;
          end
          default: ;
        endcase
      end
      if (load_out) seg_cnt_q <= seg_cnt_q + msq_pkg::INDEX_BITS'(1);
      if (fin) begin
        ul_q   <= rdata_q;
        left_q <= cur_q;
        if (col_end) begin
          col_q <= '0;
          if (row_end) begin
            row_q     <= '0;
            seg_cnt_q <= '0;
          end else begin
            row_q <= row_q + msq_pkg::ROW_BITS'(1);
          end
        end else begin
          col_q <= col_q + WB'(1);
        end
      end
    end
  end

  // datapath payload
  always_ff @(posedge clk_i) begin
    if (in_fire) cur_q <= sample_value_i;
    if (mem_we) begin
      case_q <= case_d;
      ep_q   <= '0;
      emk_q  <= 1'b0;
    end
    if (load_div) begin
      rem_q  <= RW'(num_u);
      den_q  <= den_u;
      quo_q  <= '0;
      step_q <= '0;
    end
    if (div_step) begin
      rem_q  <= {r1[RW-2:0], 1'b0};
      quo_q  <= quo_d;
      step_q <= step_q + SW'(1);
      if (step_q == SW'(FRAC_BITS)) begin
        pt_x_q[ep_q] <= px[CB-1:0];
        pt_y_q[ep_q] <= py[CB-1:0];
        ep_q         <= ep_q + 2'd1;
      end
    end
    if (state_q == msq_pkg::S_EMIT && (load_out || !seg_ok)) emk_q <= 1'b1;
    if (load_out) begin
      start_x_q <= emk_q ? pt_x_q[2] : pt_x_q[0];
      start_y_q <= emk_q ? pt_y_q[2] : pt_y_q[0];
      end_x_q   <= emk_q ? pt_x_q[3] : pt_x_q[1];
      end_y_q   <= emk_q ? pt_y_q[3] : pt_y_q[1];
      seg_idx_q <= seg_cnt_q;
      last_q    <= seg_last;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign start_x_o       = start_x_q;
  assign start_y_o       = start_y_q;
  assign end_x_o         = end_x_q;
  assign end_y_o         = end_y_q;
  assign segment_index_o = seg_idx_q;
  assign last_of_cell_o  = last_q;

  // divider never runs past its last quotient bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == msq_pkg::S_DIV) |-> (step_q <= SW'(FRAC_BITS)))
    else $error("divider step count overrun");

  // only endpoints of existing segments are computed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == msq_pkg::S_DIV) |-> (nseg != 2'd0) && (ep_q <= {nseg[1], 1'b1}))
    else $error("endpoint index beyond segment count");

  // each emitted segment takes one number
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (seg_cnt_q == $past(seg_cnt_q) + msq_pkg::INDEX_BITS'(1)))
    else $error("segment number not advanced");

  // a new segment is loaded only when the output register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten");

endmodule
